>>> rtl/cbtv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbtv_pkg;

    localparam int CELL_PIX      = 8;
    localparam int CELL_STRIDE   = 9;
    localparam int BYTE_MSB      = 7;
    localparam int GLYPH_DEPTH   = 760;
    localparam int GLYPH_AW      = 10;
    localparam int CELL_ADDR_W   = 13;
    localparam int CHAR_ADDR_W   = 10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] FIRST_PRINTABLE_RESET = 7'd32;
    localparam logic [6:0] LAST_CODE_LIMIT       = 7'h7F;
    localparam logic [3:0] WHITE_INDEX           = 4'h1;

    typedef enum logic [1:0] {
        OP_CELL   = 2'd0,
        OP_CHAR   = 2'd1,
        OP_GLYPH  = 2'd2,
        OP_RENDER = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_TEXT_ENABLE     = 3'd0,
        CFG_CURSOR_COL      = 3'd1,
        CFG_CURSOR_ROW      = 3'd2,
        CFG_CURSOR_VISIBLE  = 3'd3,
        CFG_FIRST_PRINTABLE = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        op_t                     op;
        logic                    wr_ok;
        logic [12:0]             wr_addr;
        logic [7:0]              wr_data;
        logic                    onscreen;
        logic                    in_text;
        logic [CELL_ADDR_W-1:0]  cell_addr;
        logic [CELL_ADDR_W-1:0]  color_addr;
        logic [CHAR_ADDR_W-1:0]  char_addr;
        logic [4:0]              cx;
        logic [4:0]              cy;
        logic [2:0]              row;
        logic [2:0]              col;
    } item_t;

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'hFFFFFF;
            4'd2:    rgb = 24'h880000;
            4'd3:    rgb = 24'hAAFFEE;
            4'd4:    rgb = 24'hCC44CC;
            4'd5:    rgb = 24'h00CC55;
            4'd6:    rgb = 24'h0000AA;
            4'd7:    rgb = 24'hEEEE77;
            4'd8:    rgb = 24'hDD8855;
            4'd9:    rgb = 24'h664400;
            4'd10:   rgb = 24'hFF7777;
            4'd11:   rgb = 24'h333333;
            4'd12:   rgb = 24'h777777;
            4'd13:   rgb = 24'hAAFF66;
            4'd14:   rgb = 24'h0088FF;
            4'd15:   rgb = 24'hBBBBBB;
            default: rgb = 24'h000000;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cbtv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cbtv_front #(
    parameter int CELLS_WIDE   = 32,
    parameter int CELLS_HIGH   = 24,
    parameter int TEXT_COLUMNS = 32,
    parameter int TEXT_LINES   = 24
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      operation,
    input  wire logic [12:0]     address,
    input  wire logic [7:0]      data,
    input  wire logic [7:0]      pixel_x,
    input  wire logic [7:0]      pixel_y,
    output logic                 push,
    output cbtv_pkg::item_t      push_item,
    input  wire logic            queue_full
);
    import cbtv_pkg::*;

    localparam int CELL_DEPTH = CELLS_WIDE * CELLS_HIGH * CELL_STRIDE;
    localparam int CHAR_DEPTH = TEXT_COLUMNS * TEXT_LINES;

    logic       valid_reg, valid_next;
    item_t      item_reg;
    item_t      item_new;
    logic       accept;
    logic [9:0] cell_num;
    logic [12:0] cell_base;

    assign push   = valid_reg && !queue_full;
    assign busy   = valid_reg && queue_full;
    assign accept = start && !busy;

    // classify the word and precompute the cell, colour and char addresses the back end needs
    always_comb
    begin
        item_new.op      = op_t'(operation);
        item_new.wr_addr = address;
        item_new.wr_data = data;
        case (op_t'(operation))
            OP_CELL:  item_new.wr_ok = {1'b0, address} < 14'(CELL_DEPTH);
            OP_CHAR:  item_new.wr_ok = {1'b0, address} < 14'(CHAR_DEPTH);
            OP_GLYPH: item_new.wr_ok = {1'b0, address} < 14'(GLYPH_DEPTH);
            default:  item_new.wr_ok = 1'b0;
        endcase
        item_new.cx  = pixel_x[7:3];
        item_new.cy  = pixel_y[7:3];
        item_new.row = pixel_y[2:0];
        item_new.col = pixel_x[2:0];
        item_new.onscreen = ({1'b0, pixel_x} < 9'(CELLS_WIDE * CELL_PIX))
                         && ({1'b0, pixel_y} < 9'(CELLS_HIGH * CELL_PIX));
        item_new.in_text  = ({1'b0, pixel_x[7:3]} < 6'(TEXT_COLUMNS))
                         && ({1'b0, pixel_y[7:3]} < 6'(TEXT_LINES));
        cell_num  = 10'(pixel_y[7:3] * CELLS_WIDE) + {5'd0, pixel_x[7:3]};
        cell_base = {cell_num, 3'b000} + {3'b000, cell_num};
        item_new.cell_addr  = cell_base + {10'd0, pixel_y[2:0]};
        item_new.color_addr = cell_base + 13'(CELL_PIX);
        item_new.char_addr  = 10'(pixel_y[7:3] * TEXT_COLUMNS) + {5'd0, pixel_x[7:3]};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_new;
        end
    end

    assign push_item = item_reg;

endmodule

`default_nettype wire

>>> rtl/cbtv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cbtv_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cbtv_pkg::item_t  push_item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output cbtv_pkg::item_t       head_item
);
    import cbtv_pkg::*;

    item_t                  slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full      = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cbtv_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cbtv_back #(
    parameter int CELLS_WIDE   = 32,
    parameter int CELLS_HIGH   = 24,
    parameter int TEXT_COLUMNS = 32,
    parameter int TEXT_LINES   = 24,
    parameter int GLYPH_HEIGHT = 8,
    parameter int GLYPH_WIDTH  = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             item_valid,
    input  wire cbtv_pkg::item_t  item,
    output logic                  result_valid,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);
    import cbtv_pkg::*;

    localparam int CELL_DEPTH = CELLS_WIDE * CELLS_HIGH * CELL_STRIDE;
    localparam int CELL_AW    = $clog2(CELL_DEPTH);
    localparam int CHAR_DEPTH = TEXT_COLUMNS * TEXT_LINES;
    localparam int CHAR_AW    = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;

    logic [7:0] cell_mem  [CELL_DEPTH];
    logic [7:0] char_mem  [CHAR_DEPTH];
    logic [7:0] glyph_mem [GLYPH_DEPTH];

    logic       text_enable_reg;
    logic [7:0] cursor_col_reg;
    logic [7:0] cursor_row_reg;
    logic       cursor_visible_reg;
    logic [6:0] first_printable_reg;

    // stage 1: cell and char reads
    logic       s1_valid_reg;
    logic       s1_onscreen_reg;
    logic       s1_in_text_reg;
    logic       s1_cursor_reg;
    logic [2:0] s1_row_reg;
    logic [2:0] s1_col_reg;
    logic [7:0] bits_reg;
    logic [7:0] color_reg;
    logic [7:0] ch_reg;

    // stage 2: glyph read
    logic       s2_valid_reg;
    logic       s2_onscreen_reg;
    logic       s2_overlay_reg;
    logic       s2_cursor_reg;
    logic       s2_glyph_ok_reg;
    logic       s2_in_glyph_reg;
    logic       s2_bit_reg;
    logic [7:0] s2_color_reg;
    logic [2:0] s2_col_reg;
    logic [7:0] glyph_reg;

    logic       result_valid_reg;
    logic [7:0] red_reg, green_reg, blue_reg;

    logic                render_in;
    logic                cursor_hit;
    logic                printable;
    logic [6:0]          code_offset;
    logic [GLYPH_AW-1:0] glyph_addr;
    logic                glyph_addr_ok;
    logic                glyph_bit;
    logic                pix_on;
    logic [7:0]          pix_color;
    logic [23:0]         pix_rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_enable_reg     <= 1'b0;
            cursor_col_reg      <= 8'd0;
            cursor_row_reg      <= 8'd0;
            cursor_visible_reg  <= 1'b0;
            first_printable_reg <= FIRST_PRINTABLE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_TEXT_ENABLE:     text_enable_reg     <= cfg_data[0];
                CFG_CURSOR_COL:      cursor_col_reg      <= cfg_data;
                CFG_CURSOR_ROW:      cursor_row_reg      <= cfg_data;
                CFG_CURSOR_VISIBLE:  cursor_visible_reg  <= cfg_data[0];
                CFG_FIRST_PRINTABLE: first_printable_reg <= cfg_data[6:0];
                default:             ;
            endcase
        end
    end

    assign render_in  = item_valid && (item.op == OP_RENDER);
    assign cursor_hit = cursor_visible_reg
                     && ({3'd0, item.cx} == cursor_col_reg)
                     && ({3'd0, item.cy} == cursor_row_reg);

    always_ff @(posedge clk)
    begin
        if (item_valid && item.op == OP_CELL && item.wr_ok)
        begin
            cell_mem[item.wr_addr[CELL_AW-1:0]] <= item.wr_data;
        end
        if (render_in && item.onscreen)
        begin
            bits_reg  <= cell_mem[item.cell_addr[CELL_AW-1:0]];
            color_reg <= cell_mem[item.color_addr[CELL_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item.op == OP_CHAR && item.wr_ok)
        begin
            char_mem[item.wr_addr[CHAR_AW-1:0]] <= item.wr_data;
        end
        if (render_in && item.in_text)
        begin
            ch_reg <= char_mem[item.char_addr[CHAR_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_onscreen_reg <= item.onscreen;
        s1_in_text_reg  <= item.in_text;
        s1_cursor_reg   <= cursor_hit;
        s1_row_reg      <= item.row;
        s1_col_reg      <= item.col;
    end

    // glyph address from the character code
    assign printable     = (ch_reg >= {1'b0, first_printable_reg})
                        && (ch_reg < {1'b0, LAST_CODE_LIMIT});
    assign code_offset   = ch_reg[6:0] - first_printable_reg;
    assign glyph_addr    = GLYPH_AW'(code_offset * GLYPH_HEIGHT) + {7'd0, s1_row_reg};
    assign glyph_addr_ok = glyph_addr < GLYPH_AW'(GLYPH_DEPTH);

    always_ff @(posedge clk)
    begin
        if (item_valid && item.op == OP_GLYPH && item.wr_ok)
        begin
            glyph_mem[item.wr_addr[GLYPH_AW-1:0]] <= item.wr_data;
        end
        if (s1_valid_reg && glyph_addr_ok)
        begin
            glyph_reg <= glyph_mem[glyph_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_onscreen_reg <= s1_onscreen_reg;
        s2_overlay_reg  <= text_enable_reg && s1_in_text_reg && (s1_cursor_reg || printable);
        s2_cursor_reg   <= s1_cursor_reg;
        s2_glyph_ok_reg <= glyph_addr_ok;
        s2_in_glyph_reg <= ({1'b0, s1_row_reg} < 4'(GLYPH_HEIGHT))
                        && ({1'b0, s1_col_reg} < 4'(GLYPH_WIDTH));
        s2_bit_reg      <= bits_reg[3'(BYTE_MSB) - s1_col_reg];
        s2_color_reg    <= color_reg;
        s2_col_reg      <= s1_col_reg;
    end

    always_comb
    begin
        glyph_bit = 1'b0;
        if (s2_cursor_reg)
        begin
            glyph_bit = 1'b1;
        end
        else if (s2_glyph_ok_reg)
        begin
            glyph_bit = glyph_reg[3'(BYTE_MSB) - s2_col_reg];
        end
        pix_on    = s2_bit_reg || (s2_overlay_reg && s2_in_glyph_reg && glyph_bit);
        pix_color = s2_overlay_reg ? {WHITE_INDEX, s2_color_reg[3:0]} : s2_color_reg;
        pix_rgb   = s2_onscreen_reg
                  ? palette_rgb(pix_on ? pix_color[7:4] : pix_color[3:0]) : 24'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= render_in;
            s2_valid_reg     <= s1_valid_reg;
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= pix_rgb[23:16];
        green_reg <= pix_rgb[15:8];
        blue_reg  <= pix_rgb[7:0];
    end

    assign result_valid = result_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;

`ifndef NO_ASSERTIONS
    a_render_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |=> result_valid)
        else $error("render lost in back end");

    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        !s2_valid_reg |=> !result_valid)
        else $error("result word without render");

    a_offscreen_black: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_onscreen_reg) |=> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
        else $error("offscreen pixel not black");

    a_s1_from_render: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(item_valid && item.op == OP_RENDER))
        else $error("stage 1 busy without render word");
`endif

endmodule

`default_nettype wire

>>> rtl/cell_bitmap_text_video_render.sv
`timescale 1ns / 1ps
`default_nettype none

// a render word passes front register, queue, stage 1, stage 2 and the output strobe
// throughput: one word per cycle; the back end drains the two-entry queue every cycle,
// so busy only rises if the front holds a word while the queue is full
// writes produce no word; memories are not cleared and read undefined until written
// reset: asynchronous active low, clears control state and config registers

module cell_bitmap_text_video_render #(
    parameter int CELLS_WIDE   = 32,
    parameter int CELLS_HIGH   = 24,
    parameter int TEXT_COLUMNS = 32,
    parameter int TEXT_LINES   = 24,
    parameter int GLYPH_HEIGHT = 8,
    parameter int GLYPH_WIDTH  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  operation,
    input  wire logic [12:0] address,
    input  wire logic [7:0]  data,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  pixel_y,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             result_valid,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue
);
    import cbtv_pkg::*;

    logic  push;
    item_t push_item;
    logic  queue_full;
    logic  queue_empty;
    item_t head_item;

    cbtv_front #(
        .CELLS_WIDE   (CELLS_WIDE),
        .CELLS_HIGH   (CELLS_HIGH),
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_LINES   (TEXT_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .address    (address),
        .data       (data),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    cbtv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (1'b1),
        .empty     (queue_empty),
        .head_item (head_item)
    );

    cbtv_back #(
        .CELLS_WIDE   (CELLS_WIDE),
        .CELLS_HIGH   (CELLS_HIGH),
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_LINES   (TEXT_LINES),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_WIDTH  (GLYPH_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (!queue_empty),
        .item         (head_item),
        .result_valid (result_valid),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

endmodule

`default_nettype wire

>>> tb/sv/pixel_checker.sv
`timescale 1ns / 1ps

module pixel_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  operation,
    input  wire logic [12:0] address,
    input  wire logic [7:0]  data,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  pixel_y,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        result_valid,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    output int               outstanding,
    output int               mismatches
);
    import cbtv_pkg::*;

    localparam int GRID_COLS   = 32;
    localparam int GRID_ROWS   = 24;
    localparam int TEXT_COLS   = 32;
    localparam int TEXT_ROWS   = 24;
    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_COLS  = 8;
    localparam int SCREEN_W    = GRID_COLS * CELL_PIX;
    localparam int SCREEN_H    = GRID_ROWS * CELL_PIX;
    localparam int CELL_BYTES  = GRID_COLS * GRID_ROWS * CELL_STRIDE;
    localparam int CHAR_BYTES  = TEXT_COLS * TEXT_ROWS;
    localparam int GLYPH_BYTES = GLYPH_DEPTH;

    localparam logic [23:0] palette_lut [16] = '{
        24'h000000, 24'hFFFFFF, 24'h880000, 24'hAAFFEE,
        24'hCC44CC, 24'h00CC55, 24'h0000AA, 24'hEEEE77,
        24'hDD8855, 24'h664400, 24'hFF7777, 24'h333333,
        24'h777777, 24'hAAFF66, 24'h0088FF, 24'hBBBBBB
    };

    logic [7:0]  cell_mem  [CELL_BYTES];
    logic [7:0]  char_mem  [CHAR_BYTES];
    logic [7:0]  glyph_mem [GLYPH_BYTES];

    logic        text_on;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic        cursor_on;
    logic [6:0]  first_code;

    logic [23:0] pixel_queue [$];
    int          fail_count = 0;

    function automatic logic [23:0] pixel_color(input logic [7:0] px, input logic [7:0] py);
        int         cx;
        int         cy;
        int         row;
        int         col;
        int         base;
        int         code;
        int         gaddr;
        logic [7:0] pattern;
        logic [7:0] shade;
        logic [3:0] fg;
        logic       lit;
        logic       on_cursor;
        logic       printable;
        logic       glyph_bit;
        if (int'(px) >= SCREEN_W || int'(py) >= SCREEN_H)
            return 24'h000000;
        cx      = int'(px) / CELL_PIX;
        cy      = int'(py) / CELL_PIX;
        row     = int'(py) % CELL_PIX;
        col     = int'(px) % CELL_PIX;
        base    = (cy * GRID_COLS + cx) * CELL_STRIDE;
        pattern = cell_mem[base + row];
        shade   = cell_mem[base + CELL_PIX];
        lit     = pattern[BYTE_MSB - col];
        fg      = shade[7:4];
        if (text_on && cx < TEXT_COLS && cy < TEXT_ROWS)
        begin
            code      = int'(char_mem[cy * TEXT_COLS + cx]);
            on_cursor = cursor_on && cx == int'(cur_col) && cy == int'(cur_row);
            printable = code >= int'(first_code) && code < int'(LAST_CODE_LIMIT);
            if (on_cursor || printable)
            begin
                fg = WHITE_INDEX;
                if (row < GLYPH_ROWS && col < GLYPH_COLS)
                begin
                    if (on_cursor)
                        glyph_bit = 1'b1;
                    else
                    begin
                        gaddr     = (code - int'(first_code)) * GLYPH_ROWS + row;
                        glyph_bit = gaddr < GLYPH_BYTES ? glyph_mem[gaddr][BYTE_MSB - col] : 1'b0;
                    end
                    lit = lit | glyph_bit;
                end
            end
        end
        return palette_lut[lit ? fg : shade[3:0]];
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            text_on     = 1'b0;
            cur_col     = 8'd0;
            cur_row     = 8'd0;
            cursor_on   = 1'b0;
            first_code  = FIRST_PRINTABLE_RESET;
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pixel_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: pixel expected none actual %02h%02h%02h",
                             $time, red, green, blue);
                end
                else
                begin
                    want = pixel_queue.pop_front();
                    check_field("red", want[23:16], red);
                    check_field("green", want[15:8], green);
                    check_field("blue", want[7:0], blue);
                end
            end
            if (cfg_write)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TEXT_ENABLE:     text_on    = cfg_data[0];
                    CFG_CURSOR_COL:      cur_col    = cfg_data;
                    CFG_CURSOR_ROW:      cur_row    = cfg_data;
                    CFG_CURSOR_VISIBLE:  cursor_on  = cfg_data[0];
                    CFG_FIRST_PRINTABLE: first_code = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (op_t'(operation))
                    OP_CELL:
                        if (int'(address) < CELL_BYTES)
                            cell_mem[address] = data;
                    OP_CHAR:
                        if (int'(address) < CHAR_BYTES)
                            char_mem[address] = data;
                    OP_GLYPH:
                        if (int'(address) < GLYPH_BYTES)
                            glyph_mem[address] = data;
                    default:
                        pixel_queue = {pixel_queue, pixel_color(pixel_x, pixel_y)};
                endcase
            end
            outstanding <= pixel_queue.size();
            mismatches  <= fail_count;
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cbtv_pkg::*;

    localparam int CELL_BYTES    = 32 * 24 * CELL_STRIDE;
    localparam int CHAR_BYTES    = 32 * 24;
    localparam int GLYPH_BYTES   = GLYPH_DEPTH;
    localparam int RUN_LIMIT     = 400000;
    localparam int PHASES        = 7;
    localparam int PHASE_WORDS   = 150;
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = '0;
    logic [12:0] address = '0;
    logic [7:0]  data = '0;
    logic [7:0]  pixel_x = '0;
    logic [7:0]  pixel_y = '0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;
    logic        result_valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    int          outstanding;
    int          mismatches;
    int unsigned cycle_count = 0;

    // which entries hold defined data, so no rendered pixel depends on an unwritten byte
    bit          cell_known  [CELL_BYTES];
    bit          char_known  [CHAR_BYTES];
    bit          glyph_known [GLYPH_BYTES];
    logic [7:0]  char_copy   [CHAR_BYTES];

    bit          text_on = 1'b0;
    int          cur_col = 0;
    int          cur_row = 0;
    bit          cur_vis = 1'b0;
    int          first_code = 32;
    bit          quiet = 1'b0;
    int          words_sent = 0;

    cell_bitmap_text_video_render uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .address      (address),
        .data         (data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .red          (red),
        .green        (green),
        .blue         (blue)
    );

    pixel_checker pixel_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .address      (address),
        .data         (data),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input op_t op, input logic [12:0] addr, input logic [7:0] value,
                             input logic [7:0] px, input logic [7:0] py);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        address   <= addr;
        data      <= value;
        pixel_x   <= px;
        pixel_y   <= py;
        do @(posedge clk); while (busy);
        case (op)
            OP_CELL:
                if (int'(addr) < CELL_BYTES)
                    cell_known[addr] = 1'b1;
            OP_CHAR:
                if (int'(addr) < CHAR_BYTES)
                begin
                    char_known[addr] = 1'b1;
                    char_copy[addr]  = value;
                end
            OP_GLYPH:
                if (int'(addr) < GLYPH_BYTES)
                    glyph_known[addr] = 1'b1;
            default: ;
        endcase
        words_sent++;
    endtask

    task automatic put(input op_t op, input int addr, input logic [7:0] value);
        send_word(op, 13'(addr), value, 8'($urandom), 8'($urandom));
    endtask

    task automatic draw(input int px, input int py);
        send_word(OP_RENDER, 13'($urandom), 8'($urandom), 8'(px), 8'(py));
    endtask

    task automatic set_reg(input cfg_idx_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 8'(value);
        @(posedge clk);
        case (idx)
            CFG_TEXT_ENABLE:     text_on    = value[0];
            CFG_CURSOR_COL:      cur_col    = value;
            CFG_CURSOR_ROW:      cur_row    = value;
            CFG_CURSOR_VISIBLE:  cur_vis    = value[0];
            CFG_FIRST_PRINTABLE: first_code = value;
            default: ;
        endcase
    endtask

    task automatic apply_setup(input int te, input int col, input int row, input int vis,
                               input int fp);
        set_reg(CFG_TEXT_ENABLE, te);
        set_reg(CFG_CURSOR_COL, col);
        set_reg(CFG_CURSOR_ROW, row);
        set_reg(CFG_CURSOR_VISIBLE, vis);
        set_reg(CFG_FIRST_PRINTABLE, fp);
        cfg_write <= 1'b0;
    endtask

    // hold off until every pixel is back and the write pipeline has drained
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // fills whatever the pixel will read, then renders it
    task automatic paint_pixel();
        int         px;
        int         py;
        int         cx;
        int         cy;
        int         row;
        int         base;
        int         slot;
        int         gaddr;
        logic [7:0] code;
        px = $urandom_range(0, 255);
        py = $urandom_range(0, 191);
        if (cur_vis && cur_col < 32 && cur_row < 24 && $urandom_range(0, 3) == 0)
        begin
            px = cur_col * CELL_PIX + $urandom_range(0, 7);
            py = cur_row * CELL_PIX + $urandom_range(0, 7);
        end
        cx   = px / CELL_PIX;
        cy   = py / CELL_PIX;
        row  = py % CELL_PIX;
        base = (cy * 32 + cx) * CELL_STRIDE;
        if (!cell_known[base + row] || $urandom_range(0, 3) == 0)
            put(OP_CELL, base + row, 8'($urandom));
        if (!cell_known[base + CELL_PIX] || $urandom_range(0, 3) == 0)
            put(OP_CELL, base + CELL_PIX, 8'($urandom));
        if (text_on)
        begin
            slot = cy * 32 + cx;
            if (!char_known[slot] || $urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 4) < 3)
                    code = 8'($urandom_range(first_code, 126));
                else
                    code = 8'($urandom);
                put(OP_CHAR, slot, code);
            end
            code = char_copy[slot];
            if (!(cur_vis && cx == cur_col && cy == cur_row)
                && int'(code) >= first_code && int'(code) < int'(LAST_CODE_LIMIT))
            begin
                gaddr = (int'(code) - first_code) * CELL_PIX + row;
                if (gaddr < GLYPH_BYTES && (!glyph_known[gaddr] || $urandom_range(0, 2) == 0))
                    put(OP_GLYPH, gaddr, 8'($urandom));
            end
        end
        draw(px, py);
    endtask

    task automatic noise_write();
        op_t op;
        int  limit;
        op = op_t'($urandom_range(0, 2));
        case (op)
            OP_CELL:  limit = CELL_BYTES;
            OP_CHAR:  limit = CHAR_BYTES;
            default:  limit = GLYPH_BYTES;
        endcase
        if ($urandom_range(0, 1) == 0)
            put(op, $urandom_range(0, 8191), 8'($urandom));
        else
            put(op, $urandom_range(0, limit - 1), 8'($urandom));
    endtask

    initial
    begin
        int mark;
        int pick;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bitmap only, corner cells, ignored writes, off-screen pixels
        put(OP_CELL, 0, 8'h81);
        put(OP_CELL, 8, 8'h2F);
        draw(0, 0);
        draw(1, 0);
        draw(7, 0);
        put(OP_CELL, CELL_BYTES - 2, 8'h01);
        put(OP_CELL, CELL_BYTES - 1, 8'hF0);
        draw(255, 191);
        draw(254, 191);
        put(OP_CELL, 8191, 8'hAA);
        put(OP_CHAR, CHAR_BYTES, 8'h55);
        put(OP_GLYPH, GLYPH_BYTES, 8'hFF);
        put(OP_GLYPH, 8191, 8'h00);
        draw(0, 192);
        draw(255, 255);
        settle();

        // cursor block at the origin, glyph lookup past the store in the last cell
        apply_setup(1, 0, 0, 1, 0);
        put(OP_CHAR, 0, 8'h41);
        put(OP_CHAR, CHAR_BYTES - 1, 8'd126);
        draw(0, 0);
        draw(254, 191);
        draw(255, 191);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_setup(1, 0, 0, 1, 0);
                1: apply_setup(1, 31, 23, 1, 126);
                2: apply_setup(1, 255, 255, 1, 32);
                3: apply_setup(0, 5, 5, 1, 32);
                default:
                    apply_setup($urandom_range(0, 3) != 0,
                                $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 255),
                                $urandom_range(0, 1) ? $urandom_range(0, 23) : $urandom_range(0, 255),
                                $urandom_range(0, 1),
                                $urandom_range(0, 1) ? 32 : $urandom_range(0, 126));
            endcase
            quiet = (p == 1) || ($urandom_range(0, 2) == 0);
            mark  = words_sent;
            while (words_sent - mark < PHASE_WORDS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    paint_pixel();
                else if (pick < 8)
                    draw($urandom_range(0, 255), $urandom_range(192, 255));
                else
                    noise_write();
            end
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
